// ----- sv/rsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rsa_pkg;

	// Field widths fixed by the word format
	localparam int CMD_W   = 4;
	localparam int REG_W   = 8;
	localparam int DEPTH_W = 9;
	localparam int STAT_W  = 2;

	// Free-register search: the register space is padded to its widest size
	// and split into groups; first one group is chosen, then one bit in it
	localparam int MAX_REGS  = 256;
	localparam int GRP_W     = 8;
	localparam int NUM_GRPS  = MAX_REGS / GRP_W;
	localparam int GRP_IDX_W = $clog2(NUM_GRPS);
	localparam int BIT_IDX_W = $clog2(GRP_W);

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC         = 4'd0,
		CMD_PEEK          = 4'd1,
		CMD_SWAP          = 4'd2,
		CMD_PUSH          = 4'd3,
		CMD_RELEASE       = 4'd4,
		CMD_POP           = 4'd5,
		CMD_POP_OWN       = 4'd6,
		CMD_RELEASE_OWNED = 4'd7,
		CMD_CLEAR_PINS    = 4'd8,
		CMD_FLUSH         = 4'd9
	} command_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_SHORT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GRP,
		S_BIT,
		S_SWAP_A,
		S_SWAP_B,
		S_COMMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic req_ready;
		logic find_grp;
		logic find_bit;
		logic swap_a;
		logic swap_b;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic             req_valid;
		logic [CMD_W-1:0] req_cmd;
		logic             short2;
		logic             slot_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/rsa_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rsa_req_if;
	logic                       valid;
	logic                       ready;
	logic [rsa_pkg::CMD_W-1:0]  command;
	logic [rsa_pkg::REG_W-1:0]  reg_in;
	logic                       owned_in;

	modport source (output valid, command, reg_in, owned_in, input ready);
	modport sink   (input valid, command, reg_in, owned_in, output ready);
endinterface

interface rsa_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [rsa_pkg::STAT_W-1:0]   status;
	logic [rsa_pkg::REG_W-1:0]    reg_out;
	logic                         owned_out;
	logic [rsa_pkg::REG_W-1:0]    highest_out;
	logic [rsa_pkg::DEPTH_W-1:0]  depth_out;

	modport source (output valid, status, reg_out, owned_out, highest_out, depth_out,
		input ready);
	modport sink   (input valid, status, reg_out, owned_out, highest_out, depth_out,
		output ready);
endinterface

`default_nettype wire

// ----- sv/rsa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- sv/rsa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsa_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  rsa_pkg::dp_stat_t  stat,
	output rsa_pkg::ctrl_cmd_t cmd
);

	rsa_pkg::state_t state_q, state_d;

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence one word: take it, run the extra steps it needs, then commit
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			rsa_pkg::S_IDLE: begin
				cmd.req_ready = 1'b1;
				if (stat.req_valid) begin
					case (rsa_pkg::command_t'(stat.req_cmd))
						rsa_pkg::CMD_ALLOC: state_d = rsa_pkg::S_GRP;
						rsa_pkg::CMD_SWAP:
							state_d = stat.short2 ? rsa_pkg::S_COMMIT : rsa_pkg::S_SWAP_A;
						default: state_d = rsa_pkg::S_COMMIT;
					endcase
				end
			end
			rsa_pkg::S_GRP: begin
				cmd.find_grp = 1'b1;
				state_d      = rsa_pkg::S_BIT;
			end
			rsa_pkg::S_BIT: begin
				cmd.find_bit = 1'b1;
				state_d      = rsa_pkg::S_COMMIT;
			end
			rsa_pkg::S_SWAP_A: begin
				cmd.swap_a = 1'b1;
				state_d    = rsa_pkg::S_SWAP_B;
			end
			rsa_pkg::S_SWAP_B: begin
				cmd.swap_b = 1'b1;
				state_d    = rsa_pkg::S_COMMIT;
			end
			rsa_pkg::S_COMMIT: begin
				// wait here while the output register is still occupied
				if (stat.slot_free) begin
					cmd.commit = 1'b1;
					state_d    = rsa_pkg::S_IDLE;
				end
			end
			default: state_d = rsa_pkg::S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/rsa_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsa_dp #(
	parameter int NUM_REGS = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	rsa_req_if.sink            req,
	rsa_rsp_if.source          rsp,
	input  rsa_pkg::ctrl_cmd_t cmd,
	output rsa_pkg::dp_stat_t  stat
);

	localparam int AW = $clog2(NUM_REGS);
	localparam logic [rsa_pkg::DEPTH_W-1:0] NREGS = rsa_pkg::DEPTH_W'(NUM_REGS);

	// Architectural state
	logic [NUM_REGS-1:0]             used_q;
	logic [NUM_REGS-1:0]             pinned_q;
	logic [rsa_pkg::DEPTH_W-1:0]     cnt_q;
	logic [rsa_pkg::REG_W-1:0]       high_q;

	// Latched input word
	logic [rsa_pkg::CMD_W-1:0]       cmd_q;
	logic [rsa_pkg::REG_W-1:0]       reg_q;
	logic                            own_q;

	// Search and swap scratch
	logic [rsa_pkg::GRP_IDX_W-1:0]   grp_q;
	logic                            grp_any_q;
	logic [rsa_pkg::REG_W-1:0]       alloc_idx_q;
	logic                            alloc_ok_q;
	logic [rsa_pkg::REG_W-1:0]       top_q;
	logic [rsa_pkg::REG_W-1:0]       second_q;

	// Output register
	logic                            rsp_valid_q;
	logic [rsa_pkg::STAT_W-1:0]      status_q;
	logic [rsa_pkg::REG_W-1:0]       rout_q;
	logic                            oout_q;

	// Stack memory
	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [rsa_pkg::REG_W-1:0]       ram_wdata;
	logic [AW-1:0]                   ram_raddr;
	logic [rsa_pkg::REG_W-1:0]       ram_rdata;

	logic [AW-1:0]                   addr_top;
	logic [AW-1:0]                   addr_second;
	logic [AW-1:0]                   addr_free;

	logic                            accept;
	logic                            full;
	logic                            empty;

	// Commit results
	logic [NUM_REGS-1:0]             used_d;
	logic [NUM_REGS-1:0]             pinned_d;
	logic [rsa_pkg::DEPTH_W-1:0]     cnt_d;
	logic [rsa_pkg::REG_W-1:0]       high_d;
	logic [rsa_pkg::STAT_W-1:0]      status_d;
	logic [rsa_pkg::REG_W-1:0]       rout_d;
	logic                            oout_d;
	logic                            cwr_en;
	logic [AW-1:0]                   cwr_addr;
	logic [rsa_pkg::REG_W-1:0]       cwr_data;

	// Search signals
	logic [rsa_pkg::MAX_REGS-1:0]    free_pad;
	logic [rsa_pkg::NUM_GRPS-1:0]    grp_free;
	logic [rsa_pkg::GRP_IDX_W-1:0]   grp_sel;
	logic [rsa_pkg::GRP_W-1:0]       grp_bits;
	logic [rsa_pkg::BIT_IDX_W-1:0]   bit_sel;

	assign accept      = req.valid & cmd.req_ready;
	assign full        = (cnt_q == NREGS);
	assign empty       = (cnt_q == '0);
	assign addr_top    = AW'(cnt_q - rsa_pkg::DEPTH_W'(1));
	assign addr_second = AW'(cnt_q - rsa_pkg::DEPTH_W'(2));
	assign addr_free   = AW'(cnt_q);

	// Status back to the controller
	assign req.ready      = cmd.req_ready;
	assign stat.req_valid = req.valid;
	assign stat.req_cmd   = req.command;
	assign stat.short2    = (cnt_q < rsa_pkg::DEPTH_W'(2));
	assign stat.slot_free = ~rsp_valid_q | rsp.ready;

	// Latch the input word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			reg_q <= req.reg_in;
			own_q <= req.owned_in;
		end
	end

	// Pad the free map to the full register space; absent registers read as used
	for (genvar i = 0; i < rsa_pkg::MAX_REGS; i++) begin : g_pad
		if (i < NUM_REGS) begin : g_real
			assign free_pad[i] = ~used_q[i];
		end else begin : g_none
			assign free_pad[i] = 1'b0;
		end
	end

	for (genvar g = 0; g < rsa_pkg::NUM_GRPS; g++) begin : g_grp
		assign grp_free[g] = |free_pad[g*rsa_pkg::GRP_W +: rsa_pkg::GRP_W];
	end

	// Pick the lowest group holding a free register
	always_comb begin
		grp_sel = '0;
		for (int g = rsa_pkg::NUM_GRPS - 1; g >= 0; g--) begin
			if (grp_free[g]) begin
				grp_sel = rsa_pkg::GRP_IDX_W'(g);
			end
		end
	end

	// Pick the lowest free bit in the chosen group
	assign grp_bits = free_pad[{grp_q, {rsa_pkg::BIT_IDX_W{1'b0}}} +: rsa_pkg::GRP_W];

	always_comb begin
		bit_sel = '0;
		for (int b = rsa_pkg::GRP_W - 1; b >= 0; b--) begin
			if (grp_bits[b]) begin
				bit_sel = rsa_pkg::BIT_IDX_W'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.find_grp) begin
			grp_q     <= grp_sel;
			grp_any_q <= |grp_free;
		end
		if (cmd.find_bit) begin
			alloc_idx_q <= {grp_q, bit_sel};
			alloc_ok_q  <= grp_any_q;
		end
	end

	// Swap: capture the top, then the entry below it
	always_ff @(posedge clk) begin
		if (cmd.swap_a) begin
			top_q <= ram_rdata;
		end
		if (cmd.swap_b) begin
			second_q <= ram_rdata;
		end
	end

	// Work out the effect of the latched command
	always_comb begin
		logic                      r_ok;
		logic                      t_ok;
		logic [AW-1:0]             r_idx;
		logic [AW-1:0]             t_idx;

		r_ok  = ({1'b0, reg_q} < NREGS);
		t_ok  = ({1'b0, ram_rdata} < NREGS);
		r_idx = reg_q[AW-1:0];
		t_idx = ram_rdata[AW-1:0];

		used_d   = used_q;
		pinned_d = pinned_q;
		cnt_d    = cnt_q;
		high_d   = high_q;
		status_d = rsa_pkg::STAT_OK;
		rout_d   = '0;
		oout_d   = 1'b0;
		cwr_en   = 1'b0;
		cwr_addr = addr_free;
		cwr_data = reg_q;

		case (rsa_pkg::command_t'(cmd_q))
			rsa_pkg::CMD_ALLOC: begin
				if (full || !alloc_ok_q) begin
					status_d = rsa_pkg::STAT_FULL;
				end else begin
					used_d[alloc_idx_q[AW-1:0]] = 1'b1;
					cwr_en   = 1'b1;
					cwr_data = alloc_idx_q;
					cnt_d    = cnt_q + rsa_pkg::DEPTH_W'(1);
					rout_d   = alloc_idx_q;
					if (alloc_idx_q > high_q) begin
						high_d = alloc_idx_q;
					end
				end
			end
			rsa_pkg::CMD_PEEK: begin
				if (empty) begin
					status_d = rsa_pkg::STAT_SHORT;
				end else begin
					rout_d = ram_rdata;
				end
			end
			rsa_pkg::CMD_SWAP: begin
				if (stat.short2) begin
					status_d = rsa_pkg::STAT_SHORT;
				end else begin
					cwr_en   = 1'b1;
					cwr_addr = addr_top;
					cwr_data = second_q;
				end
			end
			rsa_pkg::CMD_PUSH: begin
				if (r_ok) begin
					if (full) begin
						status_d = rsa_pkg::STAT_FULL;
					end else begin
						used_d[r_idx] = 1'b1;
						cwr_en = 1'b1;
						cnt_d  = cnt_q + rsa_pkg::DEPTH_W'(1);
						if (reg_q > high_q) begin
							high_d = reg_q;
						end
					end
				end
			end
			rsa_pkg::CMD_RELEASE: begin
				if (r_ok && !pinned_q[r_idx]) begin
					used_d[r_idx] = 1'b0;
				end
			end
			rsa_pkg::CMD_POP: begin
				if (empty) begin
					status_d = rsa_pkg::STAT_SHORT;
				end else begin
					cnt_d  = cnt_q - rsa_pkg::DEPTH_W'(1);
					rout_d = ram_rdata;
					if (t_ok && !pinned_q[t_idx]) begin
						used_d[t_idx] = 1'b0;
					end
				end
			end
			rsa_pkg::CMD_POP_OWN: begin
				if (empty) begin
					status_d = rsa_pkg::STAT_SHORT;
				end else begin
					cnt_d  = cnt_q - rsa_pkg::DEPTH_W'(1);
					rout_d = ram_rdata;
					if (t_ok && !pinned_q[t_idx]) begin
						pinned_d[t_idx] = 1'b1;
						oout_d = 1'b1;
					end
				end
			end
			rsa_pkg::CMD_RELEASE_OWNED: begin
				if (r_ok && own_q) begin
					pinned_d[r_idx] = 1'b0;
					used_d[r_idx]   = 1'b0;
				end
			end
			rsa_pkg::CMD_CLEAR_PINS: begin
				pinned_d = '0;
			end
			rsa_pkg::CMD_FLUSH: begin
				cnt_d  = '0;
				used_d = pinned_q;
			end
			default: begin
			end
		endcase
	end

	// Stack memory ports: read the top unless fetching the entry below it
	always_comb begin
		ram_raddr = cmd.swap_a ? addr_second : addr_top;
		if (cmd.swap_b) begin
			ram_we    = 1'b1;
			ram_waddr = addr_second;
			ram_wdata = top_q;
		end else begin
			ram_we    = cmd.commit & cwr_en;
			ram_waddr = cwr_addr;
			ram_wdata = cwr_data;
		end
	end

	rsa_ram #(
		.WIDTH (rsa_pkg::REG_W),
		.DEPTH (NUM_REGS)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Update maps, depth and highest on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			pinned_q <= '0;
			cnt_q    <= '0;
			high_q   <= '0;
		end else if (cmd.commit) begin
			used_q   <= used_d;
			pinned_q <= pinned_d;
			cnt_q    <= cnt_d;
			high_q   <= high_d;
		end
	end

	// Output word valid: set on commit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= status_d;
			rout_q   <= rout_d;
			oout_q   <= oout_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.reg_out     = rout_q;
	assign rsp.owned_out   = oout_q;
	assign rsp.highest_out = high_q;
	assign rsp.depth_out   = cnt_q;

endmodule

`default_nettype wire

// ----- sv/register_stack_allocator_unit.sv -----
// Register stack allocator.
// A command word enters on req (valid/ready): command, reg_in, owned_in.
// One result word leaves on rsp (valid/ready): status, reg_out, owned_out,
// highest_out and depth_out, the latter two as they stand after the command.
// Words are handled one at a time. Each word passes through these steps,
// starting with the one in which it is accepted:
//   alloc        accept, group search, bit search, commit
//   swap         accept and read the top entry, read the entry below it,
//                write the top into it, then write the entry below on commit
//   all others   accept and read the top entry, then commit (so too a short swap)
// The result register loads in the commit step.
// The result sits in an output register; req is ready again as soon as the
// commit is done, so the next word can be taken while the result waits.
// If rsp stalls, the next command waits in its commit step until the output
// register is free, and req stays low meanwhile.
// Reset clears the used and pinned maps, the stack depth and the highest
// register; stack memory contents are not cleared, and no entry at or above
// the depth is ever read.
`timescale 1ns / 1ps
`default_nettype none

module register_stack_allocator_unit #(
	parameter int NUM_REGS = 256
) (
	input wire        clk,
	input wire        arst_n,
	rsa_req_if.sink   req,
	rsa_rsp_if.source rsp
);

	rsa_pkg::ctrl_cmd_t ctrl_cmd;
	rsa_pkg::dp_stat_t  dp_stat;

	rsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (dp_stat),
		.cmd    (ctrl_cmd)
	);

	rsa_dp #(
		.NUM_REGS (NUM_REGS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (ctrl_cmd),
		.stat   (dp_stat)
	);

endmodule

`default_nettype wire
